// ===== sv/mwf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwf_pkg
// Shared types and constants of the streaming median window filter.
// ----------------------------------------------------------------------------
package mwf_pkg;

  localparam int PIX_W        = 8;
  localparam int X_W          = 10;
  localparam int Y_W          = 12;
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 12;
  localparam int CFG_DATA_W   = 12;
  localparam int CFG_INDEX_W  = 1;

  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

  localparam logic [WIDTH_REG_W-1:0]  IMAGE_WIDTH_RESET  = 11'd640;
  localparam logic [HEIGHT_REG_W-1:0] IMAGE_HEIGHT_RESET = 12'd480;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_gray;
    logic             frame_start;
  } pixel_item_t;

  typedef struct packed {
    logic [X_W-1:0] out_x;
    logic [Y_W-1:0] out_y;
    logic           frame_done;
  } pos_t;

  typedef struct packed {
    logic [PIX_W-1:0] filtered_gray;
    logic [X_W-1:0]   out_x;
    logic [Y_W-1:0]   out_y;
    logic             frame_done;
  } result_item_t;

endpackage

// ===== sv/mwf_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwf_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data that holds while the read enable is low.
// ----------------------------------------------------------------------------
module mwf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/mwf_line.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwf_line
// Raster position counters, line store memory with read-modify-write and
// same-column forwarding, and the KxK window registers.
// ----------------------------------------------------------------------------
module mwf_line
  import mwf_pkg::*;
#(
  parameter int KERNEL_SIZE = 3,
  parameter int MAX_WIDTH   = 1024
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      adv,
  input  logic                                      pixel_valid,
  input  pixel_item_t                               pixel,
  input  logic [WIDTH_REG_W-1:0]                    image_width,
  input  logic [HEIGHT_REG_W-1:0]                   image_height,
  output logic [KERNEL_SIZE*KERNEL_SIZE-1:0][PIX_W-1:0] win,
  output logic                                      win_valid,
  output pos_t                                      win_pos
);

  localparam int AREA   = KERNEL_SIZE * KERNEL_SIZE;
  localparam int KHALF  = KERNEL_SIZE / 2;
  localparam int NLINES = KERNEL_SIZE - 1;
  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int WW     = CW + 1;
  localparam int EW     = (WW > WIDTH_REG_W) ? WW : WIDTH_REG_W;

  // effective frame size
  logic [EW-1:0]           w_ext;
  logic [WW-1:0]           eff_w;
  logic [HEIGHT_REG_W-1:0] eff_h;

  assign w_ext = EW'(image_width);
  assign eff_w = (w_ext == '0) ? WW'(1) :
                 (w_ext > EW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(w_ext);
  assign eff_h = (image_height == '0) ? HEIGHT_REG_W'(1) : image_height;

  // position
  logic [CW-1:0]           col;
  logic [Y_W-1:0]          row;
  logic [CW-1:0]           cur_col;
  logic [Y_W-1:0]          cur_row;
  logic [WW-1:0]           col_inc;
  logic [Y_W:0]            row_inc;
  logic                    col_wrap;
  logic                    row_wrap;
  logic [CW-1:0]           col_next;
  logic [Y_W-1:0]          row_next;
  logic                    produce;
  logic [CW-1:0]           x_diff;
  pos_t                    cur_pos;
  logic                    accept;

  assign accept   = adv && pixel_valid;
  assign cur_col  = pixel.frame_start ? '0 : col;
  assign cur_row  = pixel.frame_start ? '0 : row;
  assign col_inc  = {1'b0, cur_col} + WW'(1);
  assign row_inc  = {1'b0, cur_row} + (Y_W + 1)'(1);
  assign col_wrap = (col_inc >= eff_w);
  assign row_wrap = (row_inc >= {1'b0, eff_h});
  assign col_next = col_wrap ? '0 : col_inc[CW-1:0];
  assign row_next = col_wrap ? (row_wrap ? '0 : row_inc[Y_W-1:0]) : cur_row;

  assign produce = ({1'b0, cur_col} < eff_w) && (cur_row < eff_h) &&
                   (cur_col >= CW'(KERNEL_SIZE - 1)) &&
                   (cur_row >= Y_W'(KERNEL_SIZE - 1));
  assign x_diff  = cur_col - CW'(KHALF);

  always_comb begin
    cur_pos.out_x      = X_W'(x_diff);
    cur_pos.out_y      = cur_row - Y_W'(KHALF);
    cur_pos.frame_done = ({1'b0, cur_col} == eff_w - WW'(1)) &&
                         (cur_row == eff_h - HEIGHT_REG_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      col <= col_next;
      row <= row_next;
    end
  end

  // stage 1: line store read data is back
  logic                          s1_valid;
  logic                          s1_produce;
  logic [PIX_W-1:0]              s1_pix;
  logic [CW-1:0]                 s1_addr;
  pos_t                          s1_pos;
  logic                          fwd_hit;
  logic [NLINES-1:0][PIX_W-1:0]  fwd_data;
  logic [NLINES*PIX_W-1:0]       ram_rdata;
  logic [NLINES-1:0][PIX_W-1:0]  old_col;
  logic [NLINES-1:0][PIX_W-1:0]  new_entry;
  logic [KERNEL_SIZE-1:0][PIX_W-1:0] column;
  logic [AREA-1:0][PIX_W-1:0]    win_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= pixel_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_produce <= produce;
      s1_pix     <= pixel.pixel_gray;
      s1_addr    <= cur_col;
      s1_pos     <= cur_pos;
      fwd_hit    <= s1_valid && (s1_addr == cur_col);
      fwd_data   <= new_entry;
    end
  end

  assign old_col = fwd_hit ? fwd_data : ram_rdata;

  always_comb begin
    for (int k = 0; k < NLINES; k++) begin
      column[k] = old_col[k];
    end
    column[NLINES] = s1_pix;
    for (int k = 0; k + 1 < NLINES; k++) begin
      new_entry[k] = old_col[k+1];
    end
    new_entry[NLINES-1] = s1_pix;
  end

  always_comb begin
    for (int r = 0; r < KERNEL_SIZE; r++) begin
      for (int k = 0; k + 1 < KERNEL_SIZE; k++) begin
        win_next[r*KERNEL_SIZE+k] = win[r*KERNEL_SIZE+k+1];
      end
      win_next[r*KERNEL_SIZE+KERNEL_SIZE-1] = column[r];
    end
  end

  mwf_ram #(
    .WIDTH (NLINES * PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (adv && s1_valid),
    .waddr (s1_addr),
    .wdata (new_entry),
    .re    (accept),
    .raddr (cur_col),
    .rdata (ram_rdata)
  );

  // window registers
  always_ff @(posedge clk) begin
    if (rst) begin
      win       <= '0;
      win_valid <= 1'b0;
    end else if (adv) begin
      win_valid <= s1_valid && s1_produce;
      if (s1_valid) begin
        win <= win_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      win_pos <= s1_pos;
    end
  end

endmodule

// ===== sv/mwf_sort.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwf_sort
// Pipelined odd-even transposition sorting network, one compare-exchange
// layer per stage, giving the middle element of the sorted window.
// ----------------------------------------------------------------------------
module mwf_sort
  import mwf_pkg::*;
#(
  parameter int AREA = 9
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  logic                        in_valid,
  input  pos_t                        in_pos,
  input  logic [AREA-1:0][PIX_W-1:0]  in_data,
  output logic                        median_valid,
  output pos_t                        median_pos,
  output logic [PIX_W-1:0]            median
);

  localparam int MID = AREA / 2;

  logic [AREA-1:0][PIX_W-1:0] stage_q [AREA];
  logic [AREA-1:0]            valid_q;
  pos_t                       pos_q [AREA];

  for (genvar s = 0; s < AREA; s++) begin : g_stage
    logic [AREA-1:0][PIX_W-1:0] src;
    logic [AREA-1:0][PIX_W-1:0] nxt;

    if (s == 0) begin : g_first
      assign src = in_data;
    end else begin : g_rest
      assign src = stage_q[s-1];
    end

    always_comb begin
      nxt = src;
      for (int i = s % 2; i + 1 < AREA; i += 2) begin
        if (src[i] > src[i+1]) begin
          nxt[i]   = src[i+1];
          nxt[i+1] = src[i];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        stage_q[s] <= nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= '0;
    end else if (adv) begin
      valid_q <= {valid_q[AREA-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pos_q[0] <= in_pos;
      for (int s = 1; s < AREA; s++) begin
        pos_q[s] <= pos_q[s-1];
      end
    end
  end

  assign median_valid = valid_q[AREA-1];
  assign median_pos   = pos_q[AREA-1];
  assign median       = stage_q[AREA-1][MID];

endmodule

// ===== sv/median_window_filter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// median_window_filter_top
// Streaming KxK median filter for 8-bit grayscale pixels in raster order.
// Path: stage-1 register, window registers, one register per sorting layer,
// output register. Throughput: one pixel per cycle unless the result side
// stalls; the line store memory is read and written once per pixel, with
// same-column forwarding between consecutive pixels.
// Reset: synchronous, clears position counters, window and pipeline valids;
// the line store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module median_window_filter_top
  import mwf_pkg::*;
#(
  parameter int KERNEL_SIZE = 3,
  parameter int MAX_WIDTH   = 1024
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   pixel_valid,
  output logic                   pixel_ready,
  input  pixel_item_t            pixel,
  output logic                   result_valid,
  input  logic                   result_ready,
  output result_item_t           result,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int AREA = KERNEL_SIZE * KERNEL_SIZE;

  logic [WIDTH_REG_W-1:0]     image_width;
  logic [HEIGHT_REG_W-1:0]    image_height;
  logic                       adv;
  logic [AREA-1:0][PIX_W-1:0] win;
  logic                       win_valid;
  pos_t                       win_pos;
  logic                       median_valid;
  pos_t                       median_pos;
  logic [PIX_W-1:0]           median;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= IMAGE_WIDTH_RESET;
      image_height <= IMAGE_HEIGHT_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[WIDTH_REG_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[HEIGHT_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // whole pipeline moves when the output register is free or being drained
  assign adv         = !result_valid || result_ready;
  assign pixel_ready = adv;

  mwf_line #(
    .KERNEL_SIZE (KERNEL_SIZE),
    .MAX_WIDTH   (MAX_WIDTH)
  ) u_line (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .pixel_valid  (pixel_valid),
    .pixel        (pixel),
    .image_width  (image_width),
    .image_height (image_height),
    .win          (win),
    .win_valid    (win_valid),
    .win_pos      (win_pos)
  );

  mwf_sort #(
    .AREA (AREA)
  ) u_sort (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .in_valid     (win_valid),
    .in_pos       (win_pos),
    .in_data      (win),
    .median_valid (median_valid),
    .median_pos   (median_pos),
    .median       (median)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= median_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result.filtered_gray <= median;
      result.out_x         <= median_pos.out_x;
      result.out_y         <= median_pos.out_y;
      result.frame_done    <= median_pos.frame_done;
    end
  end

endmodule

// ===== test/median_window_filter_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// median_window_filter_top_tb
// Streams grayscale frames of many sizes through the 3x3 median filter and
// compares every result with a cycle-free model of the line stores, window
// and position counters kept in a scoreboard. Covers out-of-range sizes,
// mid-frame restarts, register shrinks mid-frame, back-pressure and drains.
// ----------------------------------------------------------------------------
module median_window_filter_top_tb;
  import mwf_pkg::*;

  localparam int KERNEL_SIZE  = 3;
  localparam int MAX_WIDTH    = 1024;
  localparam int KHALF        = KERNEL_SIZE / 2;
  localparam int KAREA        = KERNEL_SIZE * KERNEL_SIZE;
  localparam int PIPE_LATENCY = KAREA + 2;
  localparam int HOLD_CYCLES  = 200;
  localparam int IDLE_PCT     = 16;
  localparam int MAX_SHOWN    = 40;
  localparam int RANDOM_ITEMS = 700;

  class median_scoreboard;
    bit [WIDTH_REG_W-1:0]  width_reg;
    bit [HEIGHT_REG_W-1:0] height_reg;
    bit [PIX_W-1:0]        line_mem [KERNEL_SIZE-1][MAX_WIDTH];
    bit [PIX_W-1:0]        win [KERNEL_SIZE][KERNEL_SIZE];
    int unsigned           col_cnt;
    int unsigned           row_cnt;
    result_item_t          pending_medians [$];
    int                    mismatches;
    int                    pixels_seen;
    int                    results_checked;

    function new();
      width_reg       = IMAGE_WIDTH_RESET;
      height_reg      = IMAGE_HEIGHT_RESET;
      col_cnt         = 0;
      row_cnt         = 0;
      mismatches      = 0;
      pixels_seen     = 0;
      results_checked = 0;
    endfunction

    function void set_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_IMAGE_WIDTH: begin
          width_reg = data[WIDTH_REG_W-1:0];
        end
        REG_IMAGE_HEIGHT: begin
          height_reg = data[HEIGHT_REG_W-1:0];
        end
        default: begin
        end
      endcase
    endfunction

    function bit at_origin();
      return col_cnt == 0 && row_cnt == 0;
    endfunction

    function int outstanding();
      return pending_medians.size();
    endfunction

    task report(string what);
      if (mismatches < MAX_SHOWN) $display("mismatch at %0t: %s", $realtime, what);
      mismatches++;
    endtask

    task note_pixel(pixel_item_t item);
      int unsigned    w;
      int unsigned    h;
      int unsigned    col;
      int unsigned    row;
      int unsigned    c;
      bit [PIX_W-1:0] fresh [KERNEL_SIZE];
      bit [PIX_W-1:0] flat [KAREA];
      bit [PIX_W-1:0] t;
      int             j;
      result_item_t   want;
      w = (width_reg == 0) ? 1 : width_reg;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      h = (height_reg == 0) ? 1 : height_reg;
      if (item.frame_start) begin
        col_cnt = 0;
        row_cnt = 0;
      end
      col = col_cnt;
      row = row_cnt;
      c = (col < MAX_WIDTH) ? col : MAX_WIDTH - 1;
      // new window column, oldest line first, then shift the line stores
      for (int k = 0; k < KERNEL_SIZE - 1; k++) fresh[k] = line_mem[k][c];
      fresh[KERNEL_SIZE-1] = item.pixel_gray;
      for (int k = 0; k < KERNEL_SIZE - 2; k++) line_mem[k][c] = line_mem[k+1][c];
      line_mem[KERNEL_SIZE-2][c] = item.pixel_gray;
      for (int r = 0; r < KERNEL_SIZE; r++) begin
        for (int k = 0; k < KERNEL_SIZE - 1; k++) win[r][k] = win[r][k+1];
        win[r][KERNEL_SIZE-1] = fresh[r];
      end
      pixels_seen++;
      if (col < w && row < h && col >= KERNEL_SIZE - 1 && row >= KERNEL_SIZE - 1) begin
        for (int i = 0; i < KAREA; i++) flat[i] = win[i / KERNEL_SIZE][i % KERNEL_SIZE];
        for (int i = 1; i < KAREA; i++) begin
          t = flat[i];
          j = i - 1;
          while (j >= 0 && flat[j] > t) begin
            flat[j+1] = flat[j];
            j--;
          end
          flat[j+1] = t;
        end
        want.filtered_gray = flat[KAREA/2];
        want.out_x         = X_W'(col - KHALF);
        want.out_y         = Y_W'(row - KHALF);
        want.frame_done    = (col == w - 1 && row == h - 1);
        pending_medians.insert(pending_medians.size(), want);
      end
      col++;
      if (col >= w) begin
        col = 0;
        row++;
        if (row >= h) row = 0;
      end
      col_cnt = col & 32'hFFF;
      row_cnt = row & 32'hFFF;
    endtask

    task check_result(result_item_t got);
      result_item_t want;
      if (pending_medians.size() == 0) begin
        report($sformatf("unexpected result gray %0d at (%0d,%0d)",
                         got.filtered_gray, got.out_x, got.out_y));
        return;
      end
      want = pending_medians.pop_front();
      results_checked++;
      if (got.filtered_gray !== want.filtered_gray)
        report($sformatf("median at (%0d,%0d): got %0d, want %0d", want.out_x, want.out_y,
                         got.filtered_gray, want.filtered_gray));
      if (got.out_x !== want.out_x)
        report($sformatf("out_x: got %0d, want %0d", got.out_x, want.out_x));
      if (got.out_y !== want.out_y)
        report($sformatf("out_y: got %0d, want %0d", got.out_y, want.out_y));
      if (got.frame_done !== want.frame_done)
        report($sformatf("frame_done at (%0d,%0d): got %0b, want %0b", want.out_x,
                         want.out_y, got.frame_done, want.frame_done));
    endtask

    task report_leftover();
      while (pending_medians.size() != 0) begin
        report($sformatf("missing result for (%0d,%0d)", pending_medians[0].out_x,
                         pending_medians[0].out_y));
        void'(pending_medians.pop_front());
      end
    endtask
  endclass

  logic                   clk          = 1'b0;
  logic                   rst          = 1'b1;
  logic                   pixel_valid  = 1'b0;
  logic                   pixel_ready;
  pixel_item_t            pixel        = '0;
  logic                   result_valid;
  logic                   result_ready = 1'b0;
  result_item_t           result;
  logic                   cfg_wr_en    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index    = REG_IMAGE_WIDTH;
  logic [CFG_DATA_W-1:0]  cfg_data     = '0;

  median_scoreboard sb;
  bit               sender_calm   = 1'b0;
  bit               receiver_calm = 1'b0;
  int               holds_asked   = 0;
  int               holds_done    = 0;
  int               settings_tried = 0;
  logic [PIX_W-1:0] gray_base     = '0;

  median_window_filter_top #(
    .KERNEL_SIZE(KERNEL_SIZE),
    .MAX_WIDTH  (MAX_WIDTH)
  ) DUT (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .pixel       (pixel),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) sb.check_result(result);
  end

  // result side, with random stalls and long hold-offs on request
  initial begin : result_sink
    int hold_cycles;
    hold_cycles = 0;
    forever begin
      @(negedge clk);
      if (holds_done < holds_asked) begin
        holds_done++;
        hold_cycles = HOLD_CYCLES;
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= receiver_calm ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  function automatic logic [PIX_W-1:0] pick_gray();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2, 3: return PIX_W'(gray_base + $urandom_range(0, 3));
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_pixel(input pixel_item_t p);
    while (!sender_calm && $urandom_range(0, 99) < IDLE_PCT) begin
      pixel_valid <= 1'b0;
      @(negedge clk);
    end
    pixel       <= p;
    pixel_valid <= 1'b1;
    @(posedge clk);
    while (!pixel_ready) @(posedge clk);
    sb.note_pixel(p);
    @(negedge clk);
  endtask

  task automatic send_run(input int n, input bit open_frame, input int restart_pct);
    pixel_item_t p;
    for (int i = 0; i < n; i++) begin
      p.pixel_gray = pick_gray();
      if (i == 0) p.frame_start = open_frame;
      else if (sb.at_origin()) p.frame_start = $urandom_range(0, 1);
      else p.frame_start = ($urandom_range(0, 99) < restart_pct);
      send_pixel(p);
    end
  endtask

  task automatic wait_for_results();
    pixel_valid <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (PIPE_LATENCY + 4) @(negedge clk);
  endtask

  task automatic configure(input int unsigned w, input int unsigned h);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_data  <= CFG_DATA_W'(w);
    sb.set_register(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
    @(negedge clk);
    cfg_index <= REG_IMAGE_HEIGHT;
    cfg_data  <= CFG_DATA_W'(h);
    sb.set_register(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    settings_tried++;
  endtask

  task automatic run_phase(input int unsigned w, input int unsigned h, input int n,
                           input int restart_pct);
    wait_for_results();
    configure(w, h);
    gray_base = PIX_W'($urandom_range(0, 255));
    send_run(n, 1'b1, restart_pct);
  endtask

  task automatic directed_frames();
    logic [PIX_W-1:0] checker_frame [9];
    logic [PIX_W-1:0] bright_frame [9];
    pixel_item_t      p;
    checker_frame = '{8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd128};
    bright_frame  = '{8'd255, 8'd255, 8'd1, 8'd255, 8'd0, 8'd255, 8'd128, 8'd255, 8'd2};
    configure(3, 3);
    for (int i = 0; i < 9; i++) begin
      p.pixel_gray  = checker_frame[i];
      p.frame_start = (i == 0);
      send_pixel(p);
    end
    // partial frame, then a restart in the middle of it
    for (int i = 0; i < 3; i++) begin
      p.pixel_gray  = PIX_W'($urandom_range(0, 255));
      p.frame_start = 1'b0;
      send_pixel(p);
    end
    for (int i = 0; i < 9; i++) begin
      p.pixel_gray  = bright_frame[i];
      p.frame_start = (i == 0);
      send_pixel(p);
    end
  endtask

  initial begin : stimulus
    int random_items;
    int unsigned w;
    int unsigned h;
    int n;
    sb = new();
    random_items = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    directed_frames();

    run_phase(0, 5, 12, 0);
    run_phase(2, 4, 16, 0);
    run_phase(5, 0, 15, 0);
    run_phase(6, 2, 24, 0);
    run_phase(3, 4095, 60, 0);
    run_phase(1024, 4095, 40, 0);

    // shrink width, then height, while a frame is under way
    run_phase(6, 6, 17, 0);
    wait_for_results();
    configure(4, 6);
    send_run(13, 1'b0, 0);
    send_run(18, 1'b0, 0);
    wait_for_results();
    configure(4, 3);
    send_run(14, 1'b0, 0);

    // back-pressure: long hold-off on results, then a full drain mid-frame
    wait_for_results();
    configure(7, 5);
    sender_calm   = 1'b1;
    receiver_calm = 1'b1;
    send_run(40, 1'b1, 0);
    holds_asked++;
    send_run(60, 1'b0, 0);
    wait_for_results();
    send_run(40, 1'b0, 0);
    sender_calm   = 1'b0;
    receiver_calm = 1'b0;

    // width register above the widest line
    run_phase(2047, 3, 40, 0);

    while (random_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        w = $urandom_range(13, 40);
        h = $urandom_range(3, 9);
        n = w * h + $urandom_range(0, 2 * w);
      end else begin
        w = $urandom_range(3, 12);
        h = $urandom_range(3, 9);
        n = w * h * $urandom_range(1, 3) + $urandom_range(0, 2 * w);
      end
      run_phase(w, h, n, ($urandom_range(0, 3) == 0) ? 4 : 0);
      random_items += n;
    end

    wait_for_results();
    sb.report_leftover();
    $display("%0d pixels over %0d size settings, %0d medians checked, %0d mismatches",
             sb.pixels_seen, settings_tried, sb.results_checked, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
